FILE: src/bsfd_pkg.sv
// shared constants, types and pixel format helpers for the beat synced frame delay
package bsfd_pkg;

  localparam int unsigned HISTORY_PIXELS  = 65536;
  localparam int unsigned ADDR_W          = $clog2(HISTORY_PIXELS);
  localparam int unsigned MAX_BEAT_DELAY  = 400;
  localparam int unsigned MAX_FRAME_DELAY = 200;
  localparam int unsigned MAX_BEATS       = 16;
  localparam int unsigned RING_LIMIT      = 512;
  localparam int unsigned DIM_MAX         = 256;
  localparam int unsigned ONE_Q14         = 16384;

  localparam int unsigned DIM_W   = 9;
  localparam int unsigned FP_W    = 17;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned SLOT_W  = 9;
  localparam int unsigned CAP_W   = 10;
  localparam int unsigned BIT_W   = $clog2(CAP_W);
  localparam int unsigned DELAY_W = 9;
  localparam int unsigned PROD_W  = 13;
  localparam int unsigned BEATS_W = 5;
  localparam int unsigned WORD_W  = 24;
  localparam int unsigned CFG_W   = 9;

  localparam int unsigned DEF_FRAME_WIDTH  = 64;
  localparam int unsigned DEF_FRAME_HEIGHT = 64;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_DELAY_SETTING,
    REG_USE_BEATS
  } reg_index_t;

  typedef enum logic [2:0] {
    GS_IDLE,
    GS_FP,
    GS_SEARCH,
    GS_RING,
    GS_LIMIT
  } geom_state_t;

  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic [7:0]       delay_setting;
    logic             use_beats;
  } cfg_t;

  typedef struct packed {
    logic                busy;
    logic [FP_W-1:0]     frame_pixels;
    logic [CAP_W-1:0]    slots;
    logic [ADDR_W:0]     ring_pixels;
    logic [DELAY_W-1:0]  beat_cap;
    logic [DELAY_W-1:0]  fixed_delay;
  } geom_t;

  typedef struct packed {
    logic               beat;
    logic signed [15:0] red_in;
    logic signed [15:0] green_in;
    logic signed [15:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic signed [15:0] red_out;
    logic signed [15:0] green_out;
    logic signed [15:0] blue_out;
    logic               from_history;
    logic               end_of_frame;
  } pix_out_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(DIM_MAX)) r = DIM_W'(DIM_MAX);
    else r = v;
    return r;
  endfunction

  // clamp to 0..1.0 then round to 8 bits, ties up
  function automatic logic [7:0] quantize(input logic signed [15:0] v);
    logic [14:0] c;
    logic [22:0] t;
    if (v[15]) c = '0;
    else if (v[14:0] > 15'(ONE_Q14)) c = 15'(ONE_Q14);
    else c = v[14:0];
    t = ({c, 8'b0} - {8'b0, c}) + 23'd8192;
    return t[21:14];
  endfunction

  // code * 16384 / 255 rounded: 64 * code + (64 * code + 127) / 255
  function automatic logic [15:0] expand(input logic [7:0] code);
    logic [14:0] base;
    logic [14:0] y;
    logic [14:0] q;
    base = {1'b0, code, 6'b0};
    y = base + 15'd127;
    q = (y + 15'd1 + (y >> 8)) >> 8;
    return {1'b0, base + q};
  endfunction

endpackage

FILE: src/bsfd_if.sv
// valid/ready channels for incoming pixels and delayed pixels
interface bsfd_in_if;
  logic              valid;
  logic              ready;
  bsfd_pkg::pix_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bsfd_out_if;
  logic               valid;
  logic               ready;
  bsfd_pkg::pix_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/bsfd_ram.sv
// generic single write port, single read port ram with registered read
module bsfd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read returns the old word when the same entry is written in that cycle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/bsfd_geom.sv
// frame geometry setup: frame size, ring capacity and delay limits after reset or a config change
module bsfd_geom (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  bsfd_pkg::cfg_t cfg,
  output bsfd_pkg::geom_t geom
);

  bsfd_pkg::geom_state_t state;
  bsfd_pkg::geom_state_t state_next;

  logic                                      load_fp;
  logic                                      search;
  logic                                      load_slots;
  logic                                      load_ring;
  logic                                      busy;

  logic [bsfd_pkg::BIT_W-1:0]                bit_idx;
  logic [bsfd_pkg::CAP_W-1:0]                q;
  logic [bsfd_pkg::CAP_W-1:0]                trial;
  logic [bsfd_pkg::CAP_W+bsfd_pkg::FP_W-1:0] trial_prod;
  logic                                      fits;
  logic [bsfd_pkg::CAP_W-1:0]                q_cap;
  logic [bsfd_pkg::FP_W-1:0]                 fp;
  logic [bsfd_pkg::CAP_W-1:0]                slots;
  logic [bsfd_pkg::DELAY_W-1:0]              cap_m1;
  logic [bsfd_pkg::ADDR_W:0]                 ring;
  logic [bsfd_pkg::DELAY_W-1:0]              beat_cap;
  logic [bsfd_pkg::DELAY_W-1:0]              fixed_delay;
  logic [bsfd_pkg::DELAY_W-1:0]              setting_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsfd_pkg::GS_FP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bsfd_pkg::GS_IDLE:   state_next = bsfd_pkg::GS_IDLE;
      bsfd_pkg::GS_FP:     state_next = bsfd_pkg::GS_SEARCH;
      bsfd_pkg::GS_SEARCH: begin
        if (bit_idx == '0) state_next = bsfd_pkg::GS_RING;
      end
      bsfd_pkg::GS_RING:   state_next = bsfd_pkg::GS_LIMIT;
      bsfd_pkg::GS_LIMIT:  state_next = bsfd_pkg::GS_IDLE;
      default:             state_next = bsfd_pkg::GS_IDLE;
    endcase
    // a new config write restarts the whole sequence
    if (start) state_next = bsfd_pkg::GS_FP;
  end

  always_comb begin
    load_fp    = 1'b0;
    search     = 1'b0;
    load_slots = 1'b0;
    load_ring  = 1'b0;
    busy       = 1'b1;
    unique case (state)
      bsfd_pkg::GS_IDLE:   busy = 1'b0;
      bsfd_pkg::GS_FP:     load_fp = 1'b1;
      bsfd_pkg::GS_SEARCH: search = 1'b1;
      bsfd_pkg::GS_RING:   load_slots = 1'b1;
      bsfd_pkg::GS_LIMIT:  load_ring = 1'b1;
      default:             busy = 1'b1;
    endcase
  end

  // capacity = largest q with q * fp within history, one quotient bit per cycle
  always_comb begin
    trial       = q | (bsfd_pkg::CAP_W'(1) << bit_idx);
    trial_prod  = trial * fp;
    fits        = trial_prod <= (bsfd_pkg::CAP_W + bsfd_pkg::FP_W)'(bsfd_pkg::HISTORY_PIXELS);
    q_cap       = (q == '0) ? bsfd_pkg::CAP_W'(1) : q;
    setting_lim = (cfg.delay_setting > 8'(bsfd_pkg::MAX_FRAME_DELAY))
                ? bsfd_pkg::DELAY_W'(bsfd_pkg::MAX_FRAME_DELAY)
                : bsfd_pkg::DELAY_W'(cfg.delay_setting);
  end

  always_ff @(posedge clk) begin
    if (load_fp) begin
      fp      <= bsfd_pkg::FP_W'(bsfd_pkg::clamp_dim(cfg.frame_width))
               * bsfd_pkg::FP_W'(bsfd_pkg::clamp_dim(cfg.frame_height));
      q       <= '0;
      bit_idx <= bsfd_pkg::BIT_W'(bsfd_pkg::CAP_W - 1);
    end
    if (search) begin
      if (fits) q <= trial;
      if (bit_idx != '0) bit_idx <= bit_idx - bsfd_pkg::BIT_W'(1);
    end
    if (load_slots) begin
      slots  <= (q_cap > bsfd_pkg::CAP_W'(bsfd_pkg::RING_LIMIT))
              ? bsfd_pkg::CAP_W'(bsfd_pkg::RING_LIMIT) : q_cap;
      cap_m1 <= ((q_cap - bsfd_pkg::CAP_W'(1)) > bsfd_pkg::CAP_W'(bsfd_pkg::RING_LIMIT - 1))
              ? bsfd_pkg::DELAY_W'(bsfd_pkg::RING_LIMIT - 1)
              : bsfd_pkg::DELAY_W'(q_cap - bsfd_pkg::CAP_W'(1));
    end
    if (load_ring) begin
      ring        <= (bsfd_pkg::ADDR_W + 1)'(slots * fp);
      beat_cap    <= (cap_m1 > bsfd_pkg::DELAY_W'(bsfd_pkg::MAX_BEAT_DELAY))
                   ? bsfd_pkg::DELAY_W'(bsfd_pkg::MAX_BEAT_DELAY) : cap_m1;
      fixed_delay <= (setting_lim > cap_m1) ? cap_m1 : setting_lim;
    end
  end

  always_comb begin
    geom.busy         = busy;
    geom.frame_pixels = fp;
    geom.slots        = slots;
    geom.ring_pixels  = ring;
    geom.beat_cap     = beat_cap;
    geom.fixed_delay  = fixed_delay;
  end

endmodule

FILE: src/beat_synced_frame_delay_unit.sv
// beat synced frame delay: pixel stream in, pixel from d frames back out
// an accepted request passes registers b, c, d and e; its result is valid once it reaches e
// throughput: one pixel per cycle when not stalled or in setup, one history write and one read per pixel
// reset and every config write start a geometry setup (capacity
// search, one quotient bit a cycle) during which no request is accepted
// reset clears frame state; history contents stay undefined until written
module beat_synced_frame_delay_unit (
  input  logic                          clk,
  input  logic                          rst,
  bsfd_in_if.sink                       video,
  bsfd_out_if.source                    delayed,
  input  logic                          cfg_wr_en,
  input  logic [1:0]                    cfg_index,
  input  logic [bsfd_pkg::CFG_W-1:0]    cfg_data
);

  typedef struct packed {
    logic [bsfd_pkg::ADDR_W-1:0]  waddr;
    logic [bsfd_pkg::DELAY_W-1:0] delay;
    logic [bsfd_pkg::WORD_W-1:0]  word;
    logic signed [15:0]           red;
    logic signed [15:0]           green;
    logic signed [15:0]           blue;
    logic                         hist;
    logic                         last;
  } pipe_t;

  bsfd_pkg::cfg_t  cfg;
  bsfd_pkg::geom_t geom;

  // frame state
  logic [bsfd_pkg::POS_W-1:0]   pos;
  logic [bsfd_pkg::SLOT_W-1:0]  wslot;
  logic [bsfd_pkg::ADDR_W-1:0]  wbase;
  logic [bsfd_pkg::DELAY_W-1:0] fh;
  logic [bsfd_pkg::DELAY_W-1:0] fsb;
  logic [bsfd_pkg::DELAY_W-1:0] bp;
  logic [bsfd_pkg::DELAY_W-1:0] active_delay;
  logic [bsfd_pkg::PROD_W-1:0]  bp_prod;
  logic [bsfd_pkg::PROD_W-1:0]  fsb_prod;

  // request stage
  logic                         accept;
  logic                         frame_start;
  logic [bsfd_pkg::BEATS_W-1:0] s_beats;
  logic [bsfd_pkg::DELAY_W-1:0] fsb_m1;
  logic [bsfd_pkg::DELAY_W-1:0] bp_a;
  logic [bsfd_pkg::DELAY_W-1:0] fsb_a;
  logic [bsfd_pkg::PROD_W-1:0]  bp_prod_a;
  logic [bsfd_pkg::PROD_W-1:0]  fsb_prod_a;
  logic [bsfd_pkg::DELAY_W-1:0] beat_d;
  logic [bsfd_pkg::DELAY_W-1:0] d_new;
  logic [bsfd_pkg::DELAY_W:0]   fh_inc;
  logic [bsfd_pkg::DELAY_W:0]   d_plus1;
  logic [bsfd_pkg::DELAY_W-1:0] fh_new;
  logic [bsfd_pkg::DELAY_W-1:0] d_cur;
  logic [bsfd_pkg::DELAY_W-1:0] fh_cur;
  logic                         last_a;
  logic                         wrap_a;
  pipe_t                        pipe_a;

  // pipeline
  logic                         move_b;
  logic                         move_c;
  logic                         move_d;
  logic                         move_e;
  logic                         b_valid;
  logic                         c_valid;
  logic                         d_valid;
  logic                         e_valid;
  pipe_t                        b_p;
  pipe_t                        c_p;
  pipe_t                        d_p;
  logic [bsfd_pkg::ADDR_W:0]    c_offset;
  logic                         c_under;
  logic [bsfd_pkg::ADDR_W-1:0]  c_raddr;
  logic                         ram_en;
  logic [bsfd_pkg::WORD_W-1:0]  rdata;
  logic [bsfd_pkg::WORD_W-1:0]  d_word;
  bsfd_pkg::pix_out_t           out_d;
  bsfd_pkg::pix_out_t           e_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width   <= bsfd_pkg::DIM_W'(bsfd_pkg::DEF_FRAME_WIDTH);
      cfg.frame_height  <= bsfd_pkg::DIM_W'(bsfd_pkg::DEF_FRAME_HEIGHT);
      cfg.delay_setting <= '0;
      cfg.use_beats     <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (bsfd_pkg::reg_index_t'(cfg_index))
        bsfd_pkg::REG_FRAME_WIDTH:   cfg.frame_width   <= cfg_data;
        bsfd_pkg::REG_FRAME_HEIGHT:  cfg.frame_height  <= cfg_data;
        bsfd_pkg::REG_DELAY_SETTING: cfg.delay_setting <= cfg_data[7:0];
        bsfd_pkg::REG_USE_BEATS:     cfg.use_beats     <= cfg_data[0];
      endcase
    end
  end

  bsfd_geom u_geom (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_wr_en),
    .cfg   (cfg),
    .geom  (geom)
  );

  assign move_e      = !e_valid || delayed.ready;
  assign move_d      = !d_valid || move_e;
  assign move_c      = !c_valid || move_d;
  assign move_b      = !b_valid || move_c;
  assign video.ready = move_b && !geom.busy;
  assign accept      = video.valid && video.ready;

  // per frame delay update; products beat_period * beats and
  // max(1, frames_since_beat) * beats are kept ready so no multiply sits here
  always_comb begin
    s_beats = (cfg.delay_setting > 8'(bsfd_pkg::MAX_BEATS))
            ? bsfd_pkg::BEATS_W'(bsfd_pkg::MAX_BEATS)
            : cfg.delay_setting[bsfd_pkg::BEATS_W-1:0];
    fsb_m1      = (fsb == '0) ? bsfd_pkg::DELAY_W'(1) : fsb;
    frame_start = (pos == '0);

    bp_a       = bp;
    fsb_a      = fsb;
    bp_prod_a  = bp_prod;
    fsb_prod_a = fsb_prod;
    if (video.data.beat) begin
      bp_a       = fsb_m1;
      fsb_a      = '0;
      bp_prod_a  = fsb_prod;
      fsb_prod_a = bsfd_pkg::PROD_W'(s_beats);
    end else if (fsb < bsfd_pkg::DELAY_W'(bsfd_pkg::MAX_BEAT_DELAY)) begin
      fsb_a = fsb + bsfd_pkg::DELAY_W'(1);
      if (fsb != '0) fsb_prod_a = fsb_prod + bsfd_pkg::PROD_W'(s_beats);
    end

    beat_d  = (bp_prod_a > bsfd_pkg::PROD_W'(geom.beat_cap))
            ? geom.beat_cap : bp_prod_a[bsfd_pkg::DELAY_W-1:0];
    d_new   = cfg.use_beats ? beat_d : geom.fixed_delay;
    fh_inc  = {1'b0, fh} + (bsfd_pkg::DELAY_W + 1)'(1);
    d_plus1 = {1'b0, d_new} + (bsfd_pkg::DELAY_W + 1)'(1);
    fh_new  = (fh_inc > d_plus1) ? d_plus1[bsfd_pkg::DELAY_W-1:0]
                                 : fh_inc[bsfd_pkg::DELAY_W-1:0];
    d_cur   = frame_start ? d_new : active_delay;
    fh_cur  = frame_start ? fh_new : fh;

    last_a = (bsfd_pkg::FP_W'(pos) + bsfd_pkg::FP_W'(1)) == geom.frame_pixels;
    wrap_a = (bsfd_pkg::CAP_W'(wslot) + bsfd_pkg::CAP_W'(1)) == geom.slots;

    pipe_a.waddr = bsfd_pkg::ADDR_W'(wbase + bsfd_pkg::ADDR_W'(pos));
    pipe_a.delay = d_cur;
    pipe_a.word  = {bsfd_pkg::quantize(video.data.red_in),
                    bsfd_pkg::quantize(video.data.green_in),
                    bsfd_pkg::quantize(video.data.blue_in)};
    pipe_a.red   = video.data.red_in;
    pipe_a.green = video.data.green_in;
    pipe_a.blue  = video.data.blue_in;
    pipe_a.hist  = ({1'b0, fh_cur} == ({1'b0, d_cur} + (bsfd_pkg::DELAY_W + 1)'(1)));
    pipe_a.last  = last_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      wslot        <= '0;
      wbase        <= '0;
      fh           <= '0;
      fsb          <= '0;
      bp           <= bsfd_pkg::DELAY_W'(1);
      active_delay <= '0;
    end else if (cfg_wr_en) begin
      pos   <= '0;
      wslot <= '0;
      wbase <= '0;
      fh    <= '0;
    end else if (accept) begin
      if (frame_start) begin
        bp           <= bp_a;
        fsb          <= fsb_a;
        active_delay <= d_new;
        fh           <= fh_new;
      end
      if (last_a) begin
        pos <= '0;
        if (wrap_a) begin
          wslot <= '0;
          wbase <= '0;
        end else begin
          wslot <= wslot + bsfd_pkg::SLOT_W'(1);
          wbase <= bsfd_pkg::ADDR_W'(wbase + geom.frame_pixels);
        end
      end else begin
        pos <= pos + bsfd_pkg::POS_W'(1);
      end
    end
  end

  // the beat setting may change with any config write, so refresh during setup
  always_ff @(posedge clk) begin
    if (geom.busy) begin
      bp_prod  <= bsfd_pkg::PROD_W'(bp) * bsfd_pkg::PROD_W'(s_beats);
      fsb_prod <= bsfd_pkg::PROD_W'(fsb_m1) * bsfd_pkg::PROD_W'(s_beats);
    end else if (accept && frame_start) begin
      bp_prod  <= bp_prod_a;
      fsb_prod <= fsb_prod_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else begin
      if (move_b) b_valid <= accept;
      if (move_c) c_valid <= b_valid;
      if (move_d) d_valid <= c_valid;
      if (move_e) e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_p <= pipe_a;
    end
    if (move_c && b_valid) begin
      c_p      <= b_p;
      c_offset <= (bsfd_pkg::ADDR_W + 1)'(b_p.delay * geom.frame_pixels);
    end
    if (move_d && c_valid) begin
      d_p <= c_p;
    end
    if (move_e && d_valid) begin
      e_data <= out_d;
    end
  end

  // read address is d frames back in the ring
  always_comb begin
    c_under = {1'b0, c_p.waddr} < c_offset;
    c_raddr = bsfd_pkg::ADDR_W'({1'b0, c_p.waddr}
                                + (c_under ? geom.ring_pixels : '0) - c_offset);
    ram_en  = c_valid && move_d;
  end

  bsfd_ram #(
    .WIDTH (bsfd_pkg::WORD_W),
    .DEPTH (bsfd_pkg::HISTORY_PIXELS)
  ) u_history (
    .clk   (clk),
    .we    (ram_en),
    .waddr (c_p.waddr),
    .wdata (c_p.word),
    .re    (ram_en),
    .raddr (c_raddr),
    .rdata (rdata)
  );

  // zero delay reads the entry written in the same cycle: use its own word
  always_comb begin
    d_word = (d_p.delay == '0) ? d_p.word : rdata;
    if (d_p.hist) begin
      out_d.red_out   = bsfd_pkg::expand(d_word[23:16]);
      out_d.green_out = bsfd_pkg::expand(d_word[15:8]);
      out_d.blue_out  = bsfd_pkg::expand(d_word[7:0]);
    end else begin
      out_d.red_out   = d_p.red;
      out_d.green_out = d_p.green;
      out_d.blue_out  = d_p.blue;
    end
    out_d.from_history = d_p.hist;
    out_d.end_of_frame = d_p.last;
  end

  assign delayed.valid = e_valid;
  assign delayed.data  = e_data;

  a_setup_after_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> geom.busy)
    else $error("geometry setup not started after config write");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    !geom.busy |-> (bsfd_pkg::CAP_W'(wslot) < geom.slots))
    else $error("write slot outside ring");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    !geom.busy |-> (bsfd_pkg::FP_W'(pos) < geom.frame_pixels))
    else $error("pixel position outside frame");

  a_base_match: assert property (@(posedge clk) disable iff (rst)
    !geom.busy |-> (wbase == (bsfd_pkg::ADDR_W)'(wslot * geom.frame_pixels)))
    else $error("frame base address out of step with write slot");

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, fh} <= ({1'b0, active_delay} + (bsfd_pkg::DELAY_W + 1)'(1)))
    else $error("more frames held than delay needs");

endmodule

FILE: tb/tb_beat_synced_frame_delay_unit.sv
`timescale 1ns / 1ps
// self-checking testbench for the beat synced frame delay unit
module tb_beat_synced_frame_delay_unit;
  import bsfd_pkg::*;

  localparam int unsigned RUN_ITEMS   = 1750;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned IDLE_PCT    = 13;

  // predicts the delayed pixel stream and holds what is still to come out
  class frame_delay_scoreboard;
    logic [DIM_W-1:0] width_cfg;
    logic [DIM_W-1:0] height_cfg;
    logic [7:0]       delay_cfg;
    logic             beats_cfg;
    bit [WORD_W-1:0]  history [HISTORY_PIXELS];
    int unsigned      held, slot, pos, since_beat, period, delay_frames;
    pix_out_t         expected_q [int unsigned];
    int unsigned      queued, taken;
    int unsigned      failures, results, from_hist, frames;

    function new();
      width_cfg    = DEF_FRAME_WIDTH;
      height_cfg   = DEF_FRAME_HEIGHT;
      delay_cfg    = '0;
      beats_cfg    = 1'b0;
      since_beat   = 0;
      period       = 1;
      delay_frames = 0;
      clear_history();
    endfunction

    function void clear_history();
      held = 0;
      slot = 0;
      pos  = 0;
    endfunction

    function int unsigned dim(logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > DIM_MAX) return DIM_MAX;
      return v;
    endfunction

    function int unsigned frame_size();
      return dim(width_cfg) * dim(height_cfg);
    endfunction

    function int unsigned capacity();
      int unsigned c;
      c = HISTORY_PIXELS / frame_size();
      return (c < 1) ? 1 : c;
    endfunction

    function int unsigned ring_size();
      int unsigned c;
      c = capacity();
      return (c > RING_LIMIT) ? RING_LIMIT : c;
    endfunction

    // clamp to 0..1.0, round to nearest 8 bit code with ties up
    function bit [7:0] to_code(logic signed [15:0] v);
      int c;
      c = v;
      if (c < 0) c = 0;
      if (c > int'(ONE_Q14)) c = ONE_Q14;
      return 8'((c * 255 + 8192) >>> 14);
    endfunction

    function logic [15:0] from_code(bit [7:0] code);
      return 16'((int'(code) * ONE_Q14 + 127) / 255);
    endfunction

    function void set_register(reg_index_t idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_FRAME_WIDTH:   width_cfg = value;
        REG_FRAME_HEIGHT:  height_cfg = value;
        REG_DELAY_SETTING: delay_cfg = value[7:0];
        REG_USE_BEATS:     beats_cfg = value[0];
      endcase
      clear_history();
    endfunction

    function void new_frame(bit beat);
      int unsigned d, s, cap;
      frames++;
      if (beat) begin
        period = (since_beat < 1) ? 1 : since_beat;
        since_beat = 0;
      end else if (since_beat < MAX_BEAT_DELAY) begin
        since_beat++;
      end
      if (beats_cfg) begin
        s = (delay_cfg > MAX_BEATS) ? MAX_BEATS : delay_cfg;
        d = period * s;
        if (d > MAX_BEAT_DELAY) d = MAX_BEAT_DELAY;
      end else begin
        d = (delay_cfg > MAX_FRAME_DELAY) ? MAX_FRAME_DELAY : delay_cfg;
      end
      cap = capacity();
      if (d > cap - 1) d = cap - 1;
      delay_frames = d;
      // frames older than the new delay fall out of the window
      held++;
      if (held > delay_frames + 1) held = delay_frames + 1;
    endfunction

    function void note_request(pix_in_t p);
      int unsigned fp, ring, addr, rslot;
      bit [WORD_W-1:0] word;
      pix_out_t r;
      fp = frame_size();
      ring = ring_size();
      if (pos >= fp) pos = 0;
      if (slot >= ring) slot = 0;
      if (pos == 0) new_frame(p.beat);
      word = {to_code(p.red_in), to_code(p.green_in), to_code(p.blue_in)};
      addr = slot * fp + pos;
      if (addr < HISTORY_PIXELS) history[addr] = word;
      if (held == delay_frames + 1) begin
        rslot = (slot + ring - (delay_frames % ring)) % ring;
        addr = rslot * fp + pos;
        word = (addr < HISTORY_PIXELS) ? history[addr] : '0;
        r.red_out      = from_code(word[23:16]);
        r.green_out    = from_code(word[15:8]);
        r.blue_out     = from_code(word[7:0]);
        r.from_history = 1'b1;
        from_hist++;
      end else begin
        r.red_out      = p.red_in;
        r.green_out    = p.green_in;
        r.blue_out     = p.blue_in;
        r.from_history = 1'b0;
      end
      r.end_of_frame = (pos + 1 >= fp);
      if (pos + 1 >= fp) begin
        pos = 0;
        slot = (slot + 1) % ring;
      end else begin
        pos++;
      end
      expected_q[queued] = r;
      queued++;
    endfunction

    function void report(string msg);
      failures++;
      $error("%s", msg);
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want)
        report($sformatf("%s: expected %0d, got %0d", field, $signed(want), $signed(got)));
    endfunction

    function void check_result(pix_out_t got);
      pix_out_t want;
      results++;
      if (taken == queued) begin
        report("delayed pixel with no request pending");
        return;
      end
      want = expected_q[taken];
      expected_q.delete(taken);
      taken++;
      compare("red_out", want.red_out, got.red_out);
      compare("green_out", want.green_out, got.green_out);
      compare("blue_out", want.blue_out, got.blue_out);
      compare("from_history", 16'(want.from_history), 16'(got.from_history));
      compare("end_of_frame", 16'(want.end_of_frame), 16'(got.end_of_frame));
    endfunction

    function int unsigned pending();
      return queued - taken;
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bsfd_in_if  video();
  bsfd_out_if delayed();

  frame_delay_scoreboard sb;
  int unsigned cycles;
  int unsigned sent;
  int unsigned reg_writes;
  bit          steady;

  logic signed [15:0] corner_values [0:9] = '{16'sh8000, -16'sd1, 16'sd0, 16'sd1,
    16'sd8191, 16'sd8192, 16'sd16383, 16'sd16384, 16'sd16385, 16'sh7fff};

  beat_synced_frame_delay_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .video     (video),
    .delayed   (delayed),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_beat_synced_frame_delay_unit NOT OK");
      $finish;
    end
  end

  // watch both channels and the register port
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_wr_en === 1'b1) sb.set_register(reg_index_t'(cfg_index), cfg_data);
      if (video.valid === 1'b1 && video.ready === 1'b1) sb.note_request(video.data);
      if (delayed.valid === 1'b1 && delayed.ready === 1'b1) sb.check_result(delayed.data);
    end
  end

  always @(negedge clk) begin
    delayed.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic logic signed [15:0] random_channel();
    case ($urandom_range(9))
      0, 1, 2, 3: return 16'($urandom_range(ONE_Q14));
      4, 5, 6:    return 16'($urandom);
      7:          return 16'($urandom_range(ONE_Q14 - 64, ONE_Q14 + 64));
      8:          return 16'(int'($urandom_range(128)) - 64);
      default:    return corner_values[$urandom_range(9)];
    endcase
  endfunction

  function automatic pix_in_t random_pixel(bit beat);
    pix_in_t p;
    p.beat     = beat;
    p.red_in   = random_channel();
    p.green_in = random_channel();
    p.blue_in  = random_channel();
    return p;
  endfunction

  // mostly tiny frames so that many frames pass; now and then the extremes
  function automatic int unsigned random_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 4);
    if (r < 80) return $urandom_range(5, 16);
    if (r < 88) return 0;
    if (r < 94) return DIM_MAX;
    return $urandom_range(DIM_MAX + 1, 511);
  endfunction

  function automatic int unsigned random_delay();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return $urandom_range(0, 6);
    if (r < 75) return $urandom_range(7, MAX_BEATS + 1);
    if (r < 85) return 255;
    if (r < 90) return $urandom_range(MAX_FRAME_DELAY, MAX_FRAME_DELAY + 1);
    return $urandom_range(255);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_pixel(input pix_in_t p);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      video.valid <= 1'b0;
      @(negedge clk);
    end
    video.valid <= 1'b1;
    video.data  <= p;
    do @(posedge clk); while (video.ready !== 1'b1);
    sent++;
    @(negedge clk);
  endtask

  task automatic stop_and_drain();
    video.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input int unsigned value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    reg_writes++;
  endtask

  task automatic run_phase(input int unsigned stop_at);
    int unsigned count, beat_chance, n;
    bit long_run;
    long_run = ($urandom_range(7) == 0);
    // long runs use one or two pixel frames to reach deep delays and ring wrap
    if (long_run) begin
      write_reg(REG_FRAME_WIDTH, 1);
      write_reg(REG_FRAME_HEIGHT, $urandom_range(1, 2));
    end else begin
      if ($urandom_range(1)) write_reg(REG_FRAME_WIDTH, random_dim());
      if ($urandom_range(1)) write_reg(REG_FRAME_HEIGHT, random_dim());
    end
    if ($urandom_range(1)) write_reg(REG_DELAY_SETTING, random_delay());
    if ($urandom_range(2) == 0) write_reg(REG_USE_BEATS, $urandom_range(1));
    case ($urandom_range(4))
      0:       beat_chance = 0;
      1:       beat_chance = 5;
      2:       beat_chance = 25;
      3:       beat_chance = 50;
      default: beat_chance = 100;
    endcase
    count = long_run ? $urandom_range(300, 600) : $urandom_range(20, 120);
    for (n = 0; n < count && sent < stop_at; n++) begin
      steady = (sent >= 800 && sent < 1100);
      send_pixel(random_pixel($urandom_range(99) < beat_chance));
    end
    steady = 1'b0;
    stop_and_drain();
  endtask

  initial begin
    pix_in_t     px;
    int unsigned i;
    int unsigned stop_at;
    sb = new();
    sent = 0;
    reg_writes = 0;
    steady = 1'b0;
    rst = 1'b1;
    video.valid = 1'b0;
    video.data = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero delay after reset: every channel corner goes through quantize and expand
    for (i = 0; i < 10; i++) begin
      px.beat     = i[0];
      px.red_in   = corner_values[i];
      px.green_in = corner_values[9 - i];
      px.blue_in  = corner_values[(i + 3) % 10];
      send_pixel(px);
    end
    stop_and_drain();

    // zero height counts as one line: two frames pass through, then history
    write_reg(REG_FRAME_WIDTH, 1);
    write_reg(REG_FRAME_HEIGHT, 0);
    write_reg(REG_DELAY_SETTING, 2);
    write_reg(REG_USE_BEATS, 0);
    for (i = 0; i < 4; i++) send_pixel(random_pixel(1'b0));
    stop_and_drain();

    // delay in beat periods, period changing between beats
    write_reg(REG_USE_BEATS, 1);
    write_reg(REG_DELAY_SETTING, 1);
    for (i = 0; i < 6; i++) send_pixel(random_pixel(i == 0 || i == 2 || i == 5));
    stop_and_drain();

    // oversized width counts as 256: one frame fills the history, delay capped to zero
    write_reg(REG_FRAME_WIDTH, 511);
    write_reg(REG_FRAME_HEIGHT, DIM_MAX);
    for (i = 0; i < 3; i++) send_pixel(random_pixel(1'b1));
    stop_and_drain();

    // largest setting in frame mode is capped at the frame delay limit
    write_reg(REG_FRAME_WIDTH, 1);
    write_reg(REG_FRAME_HEIGHT, 1);
    write_reg(REG_USE_BEATS, 0);
    write_reg(REG_DELAY_SETTING, 255);
    for (i = 0; i < 3; i++) send_pixel(random_pixel(1'b0));
    stop_and_drain();

    stop_at = sent + RUN_ITEMS;
    while (sent < stop_at) run_phase(stop_at);

    repeat (16) @(negedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d delayed pixels never arrived", sb.pending()));
    $display("checked %0d pixels over %0d frames and %0d register writes",
             sb.results, sb.frames, reg_writes);
    $display("%0d pixels came out of the frame history, the rest passed through",
             sb.from_hist);
    if (sb.failures == 0) begin
      $display("tb_beat_synced_frame_delay_unit OK");
    end else begin
      $display("tb_beat_synced_frame_delay_unit NOT OK");
    end
    $finish;
  end

endmodule

FILE: beat_synced_frame_delay_unit.f
src/bsfd_pkg.sv
src/bsfd_if.sv
src/bsfd_ram.sv
src/bsfd_geom.sv
src/beat_synced_frame_delay_unit.sv
tb/tb_beat_synced_frame_delay_unit.sv
